// ----- hdl/wbfp_pkg.sv -----
// ----------------------------------------------------------------------------
// wbfp_pkg
// Shared types, constants and helpers of the beacon frame parser.
// ----------------------------------------------------------------------------
package wbfp_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 4096;
  localparam int unsigned MIN_FRAME_BYTES = 40;
  localparam int unsigned FCS_BYTES       = 4;
  localparam int unsigned HDR_BYTES       = 36;
  localparam int unsigned VEND_BYTES      = 21;
  localparam int unsigned MAGIC_BYTES     = 8;
  localparam int unsigned NUM_WORDS       = 9;
  localparam logic [7:0]  VENDOR_ID       = 8'd221;
  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam int unsigned PADDR_W         = 4;

  localparam logic [PADDR_W-1:0] ADDR_MAGIC = '0;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_SUM  = 2'd2;

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_DATA
  } wbfp_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] id;
    logic [7:0] val;
  } wbfp_walk_t;

  typedef struct packed {
    logic [1:0]                 nwalk;
    logic                       has_sum;
    wbfp_walk_t [1:0]           walk;
    logic [NUM_WORDS-1:0][63:0] words;
  } wbfp_bundle_t;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/wbfp_in_if.sv -----
// ----------------------------------------------------------------------------
// wbfp_in_if
// Frame byte channel: one byte and its end flag per beat.
// ----------------------------------------------------------------------------
interface wbfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_frame;

  modport source (output valid, output data_byte, output end_of_frame, input ready);
  modport sink (input valid, input data_byte, input end_of_frame, output ready);
endinterface

// ----- hdl/wbfp_out_if.sv -----
// ----------------------------------------------------------------------------
// wbfp_out_if
// Result channel: element bytes, element end markers and summary words.
// ----------------------------------------------------------------------------
interface wbfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  word_index;
  logic [7:0]  element_id;
  logic [63:0] value;
  logic        last;

  modport source (output valid, output kind, output word_index, output element_id,
                  output value, output last, input ready);
  modport sink (input valid, input kind, input word_index, input element_id,
                input value, input last, output ready);
endinterface

// ----- hdl/wifi_beacon_frame_parser.sv -----
// ----------------------------------------------------------------------------
// wifi_beacon_frame_parser
// 802.11 beacon parser: one frame byte per beat in, element bytes, element
// end markers and nine summary words per frame out.
// Results are registered; a byte's first shows in the cycle after its beat.
// One byte per cycle while a byte gives at most one result and the sink is
// ready; a byte with more results holds the input while the result register
// sends them one per ready cycle. Synchronous reset clears frame state.
// ----------------------------------------------------------------------------
module wifi_beacon_frame_parser import wbfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  wbfp_in_if.sink            in_ch,
  wbfp_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [63:0]  magic_word;
  logic         accept;
  logic         load;
  logic         free;
  wbfp_bundle_t bundle;

  assign pready       = 1'b1;
  assign prdata       = (paddr[PADDR_W-1] == ADDR_MAGIC[PADDR_W-1]) ? magic_word : 64'd0;
  assign in_ch.ready  = free;
  assign accept       = in_ch.valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= '0;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == ADDR_MAGIC[PADDR_W-1]) begin
      magic_word <= pwdata;
    end
  end

  wbfp_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (in_ch.data_byte),
    .end_of_frame (in_ch.end_of_frame),
    .magic_word   (magic_word),
    .load         (load),
    .bundle       (bundle)
  );

  wbfp_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .bundle (bundle),
    .free   (free),
    .o      (out_ch)
  );

endmodule

// ----- hdl/wbfp_core.sv -----
// ----------------------------------------------------------------------------
// wbfp_core
// Per-byte frame state: FCS delay, CRC, header store, element walk, vendor
// capture; builds the result bundle of each accepted byte.
// ----------------------------------------------------------------------------
module wbfp_core import wbfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         end_of_frame,
  input  logic [63:0]  magic_word,
  output logic         load,
  output wbfp_bundle_t bundle
);

  logic [7:0]  fcs_delay [FCS_BYTES];
  logic [15:0] byte_count;
  logic [31:0] crc_accum;
  logic [7:0]  header_store [HDR_BYTES];
  wbfp_phase_t walk_phase;
  logic [7:0]  cur_element_id;
  logic [7:0]  bytes_left;
  logic [7:0]  pos_in_element;
  logic [7:0]  vendor_shadow [VEND_BYTES];
  logic [7:0]  vendor_committed [VEND_BYTES];
  logic        vendor_seen;

  logic [7:0]  fcs_next [FCS_BYTES];
  logic [15:0] byte_count_next;
  logic [31:0] crc_next;
  logic [7:0]  hdr_next [HDR_BYTES];
  wbfp_phase_t phase_next;
  logic [7:0]  id_next;
  logic [7:0]  left_next;
  logic [7:0]  pos_next;
  logic [7:0]  shadow_next [VEND_BYTES];
  logic [7:0]  comm_next [VEND_BYTES];
  logic        seen_next;

  logic        body_en;
  logic [7:0]  body;
  logic [15:0] k;
  logic        done;
  logic [7:0]  left_dec;
  logic [7:0]  pos_inc;

  logic [15:0] fc;
  logic [31:0] fcs_word;
  logic        fcs_ok;
  logic        mgmt;
  logic        beacon;
  logic        walk_ok;
  logic [63:0] magic;
  logic        zero_hit;
  logic        is_short;

  always_comb begin
    body     = fcs_delay[0];
    body_en  = (byte_count >= 16'(FCS_BYTES));
    k        = byte_count - 16'(FCS_BYTES);
    left_dec = bytes_left - 8'd1;
    pos_inc  = pos_in_element + 8'd1;
    done     = 1'b0;

    fcs_next[0] = fcs_delay[1];
    fcs_next[1] = fcs_delay[2];
    fcs_next[2] = fcs_delay[3];
    fcs_next[3] = data_byte;
    byte_count_next = (byte_count < 16'(MAX_FRAME_BYTES)) ? byte_count + 16'd1 : byte_count;
    crc_next   = body_en ? crc_step(crc_accum, body) : crc_accum;
    hdr_next   = header_store;
    shadow_next = vendor_shadow;
    comm_next  = vendor_committed;
    seen_next  = vendor_seen;
    phase_next = walk_phase;
    id_next    = cur_element_id;
    left_next  = bytes_left;
    pos_next   = pos_in_element;

    bundle.nwalk   = 2'd0;
    bundle.has_sum = end_of_frame;
    bundle.walk    = '0;

    if (body_en) begin
      if (k < 16'(HDR_BYTES)) begin
        hdr_next[k[5:0]] = body;
      end else begin
        case (walk_phase)
          PH_ID: begin
            id_next    = body;
            phase_next = PH_LEN;
          end
          PH_LEN: begin
            left_next = body;
            pos_next  = 8'd0;
            if (body == 8'd0) begin
              phase_next          = PH_ID;
              bundle.nwalk        = 2'd1;
              bundle.walk[0].kind = KIND_END;
              bundle.walk[0].id   = cur_element_id;
              bundle.walk[0].val  = 8'd0;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            if (pos_in_element < 8'(VEND_BYTES)) begin
              shadow_next[pos_in_element[4:0]] = body;
            end
            bundle.nwalk        = 2'd1;
            bundle.walk[0].kind = KIND_DATA;
            bundle.walk[0].id   = cur_element_id;
            bundle.walk[0].val  = body;
            pos_next  = pos_inc;
            left_next = left_dec;
            if (left_dec == 8'd0) begin
              done                = 1'b1;
              phase_next          = PH_ID;
              bundle.nwalk        = 2'd2;
              bundle.walk[1].kind = KIND_END;
              bundle.walk[1].id   = cur_element_id;
              bundle.walk[1].val  = pos_inc;
            end
          end
          default: begin
            phase_next = PH_ID;
          end
        endcase
      end
    end

    if (done && cur_element_id == VENDOR_ID && pos_inc >= 8'(VEND_BYTES)) begin
      comm_next = shadow_next;
      seen_next = 1'b1;
    end

    fc       = {hdr_next[1], hdr_next[0]};
    fcs_word = {fcs_next[3], fcs_next[2], fcs_next[1], fcs_next[0]};
    fcs_ok   = (~crc_next == fcs_word);
    mgmt     = (fc[3:2] == 2'd0);
    beacon   = mgmt && (fc[7:4] == 4'd8);
    walk_ok  = beacon && (phase_next == PH_ID);
    is_short = (byte_count_next < 16'(MIN_FRAME_BYTES));
    magic    = '0;
    zero_hit = 1'b0;
    for (int i = 0; i < MAGIC_BYTES; i++) begin
      if (comm_next[4 + i] == 8'd0) begin
        zero_hit = 1'b1;
      end
      if (!zero_hit) begin
        magic[8*i +: 8] = comm_next[4 + i];
      end
    end

    bundle.words = '0;
    if (is_short) begin
      bundle.words[0] = 64'd1;
    end else begin
      bundle.words[0] = {32'd0, hdr_next[35], hdr_next[34], 9'd0,
                         seen_next && (magic == magic_word), seen_next, walk_ok,
                         beacon, mgmt, fcs_ok, 1'b0};
      bundle.words[1] = {hdr_next[33], hdr_next[32], hdr_next[23], hdr_next[22],
                         hdr_next[3], hdr_next[2], fc};
      bundle.words[2] = {16'd0, hdr_next[9], hdr_next[8], hdr_next[7], hdr_next[6],
                         hdr_next[5], hdr_next[4]};
      bundle.words[3] = {16'd0, hdr_next[15], hdr_next[14], hdr_next[13], hdr_next[12],
                         hdr_next[11], hdr_next[10]};
      bundle.words[4] = {16'd0, hdr_next[21], hdr_next[20], hdr_next[19], hdr_next[18],
                         hdr_next[17], hdr_next[16]};
      bundle.words[5] = {hdr_next[31], hdr_next[30], hdr_next[29], hdr_next[28],
                         hdr_next[27], hdr_next[26], hdr_next[25], hdr_next[24]};
      bundle.words[6] = {8'd0, comm_next[13], comm_next[14], comm_next[12],
                         comm_next[3], comm_next[2], comm_next[1], comm_next[0]};
      bundle.words[7] = {16'd0, comm_next[17], comm_next[18], comm_next[19],
                         comm_next[20], comm_next[15], comm_next[16]};
      bundle.words[8] = magic;
    end
  end

  assign load = accept && ((bundle.nwalk != 2'd0) || end_of_frame);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FCS_BYTES; i++) fcs_delay[i] <= 8'd0;
      for (int i = 0; i < VEND_BYTES; i++) vendor_committed[i] <= 8'd0;
      byte_count     <= '0;
      crc_accum      <= '1;
      walk_phase     <= PH_ID;
      cur_element_id <= '0;
      bytes_left     <= '0;
      pos_in_element <= '0;
      vendor_seen    <= 1'b0;
    end else if (accept) begin
      if (end_of_frame) begin
        for (int i = 0; i < FCS_BYTES; i++) fcs_delay[i] <= 8'd0;
        for (int i = 0; i < VEND_BYTES; i++) vendor_committed[i] <= 8'd0;
        byte_count     <= '0;
        crc_accum      <= '1;
        walk_phase     <= PH_ID;
        cur_element_id <= '0;
        bytes_left     <= '0;
        pos_in_element <= '0;
        vendor_seen    <= 1'b0;
      end else begin
        fcs_delay        <= fcs_next;
        vendor_committed <= comm_next;
        byte_count       <= byte_count_next;
        crc_accum        <= crc_next;
        walk_phase       <= phase_next;
        cur_element_id   <= id_next;
        bytes_left       <= left_next;
        pos_in_element   <= pos_next;
        vendor_seen      <= seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      header_store  <= hdr_next;
      vendor_shadow <= shadow_next;
    end
  end

endmodule

// ----- hdl/wbfp_out.sv -----
// ----------------------------------------------------------------------------
// wbfp_out
// Result register: holds one bundle and sends its results one beat each.
// ----------------------------------------------------------------------------
module wbfp_out import wbfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  wbfp_bundle_t bundle,
  output logic         free,
  wbfp_out_if.source   o
);

  wbfp_bundle_t held;
  logic         busy;
  logic [3:0]   pos;
  logic [3:0]   total;
  logic [3:0]   widx;
  logic         is_last;

  always_comb begin
    total   = {2'd0, held.nwalk} + (held.has_sum ? 4'(NUM_WORDS) : 4'd0);
    widx    = pos - {2'd0, held.nwalk};
    is_last = (pos == total - 4'd1);
    free    = !busy || (o.ready && is_last);

    o.valid = busy;
    o.last  = is_last;
    if (pos < {2'd0, held.nwalk}) begin
      o.kind       = held.walk[pos[0]].kind;
      o.word_index = 4'd0;
      o.element_id = held.walk[pos[0]].id;
      o.value      = {56'd0, held.walk[pos[0]].val};
    end else begin
      o.kind       = KIND_SUM;
      o.word_index = widx;
      o.element_id = 8'd0;
      o.value      = (widx < 4'(NUM_WORDS)) ? held.words[widx] : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (busy && o.ready) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) busy |-> (pos < total))
    else $error("result position beyond bundle");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || (o.ready && is_last)))
    else $error("bundle loaded over pending results");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    (busy && o.ready && !is_last) |=> (busy && pos == $past(pos) + 4'd1))
    else $error("result sequence did not advance");
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    load |-> (bundle.nwalk != 2'd0 || bundle.has_sum))
    else $error("empty bundle loaded");

endmodule

// ----- verif/wifi_beacon_frame_parser_tb.sv -----
// ----------------------------------------------------------------------------
// wifi_beacon_frame_parser_tb
// Streams 802.11 frames through the beacon parser with random gaps on both
// channels, predicts every element byte, end marker and summary word, and
// checks each output beat in order. The magic register is rewritten between
// phases while the parser is idle.
// ----------------------------------------------------------------------------
module wifi_beacon_frame_parser_tb import wbfp_pkg::*; ();

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  word_index;
    logic [7:0]  element_id;
    logic [63:0] value;
    logic        last;
  } result_t;

  typedef struct {
    logic [7:0] b;
    logic       eof;
  } beat_t;

  typedef struct {
    logic [7:0]  b;
    logic        eof;
    logic        chk;
    logic [1:0]  kind;
    logic [3:0]  widx;
    logic [63:0] val;
  } row_t;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  wbfp_in_if  in_ch ();
  wbfp_out_if out_ch ();

  wifi_beacon_frame_parser dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // parser shadow state
  logic [63:0] p_magic;
  logic [7:0]  p_delay [4];
  int unsigned p_count;
  logic [31:0] p_crc;
  logic [7:0]  p_hdr [36];
  wbfp_phase_t p_phase;
  logic [7:0]  p_id;
  logic [7:0]  p_left;
  logic [7:0]  p_pos;
  logic [7:0]  p_vshadow [21];
  logic [7:0]  p_vcommit [21];
  logic        p_vseen;

  result_t expected_results [$];
  beat_t   pending_beats [$];
  row_t    directed_rows [$];
  int      errors = 0;
  int      idle_cycles = 0;
  bit      timed_out = 0;
  int      sink_hold = 0;

  function automatic void clear_frame();
    for (int i = 0; i < 4; i++) p_delay[i] = '0;
    p_count = 0;
    p_crc = '1;
    p_phase = PH_ID;
    p_id = '0;
    p_left = '0;
    p_pos = '0;
    for (int i = 0; i < 21; i++) p_vcommit[i] = '0;
    p_vseen = 1'b0;
  endfunction

  function automatic void push_result(logic [1:0] k, logic [3:0] w, logic [7:0] id,
                                      logic [63:0] v);
    result_t r;
    r.kind = k; r.word_index = w; r.element_id = id; r.value = v; r.last = 1'b0;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic logic [63:0] hdr_bytes(int off, int len);
    logic [63:0] v = '0;
    for (int i = 0; i < len; i++) v |= 64'(p_hdr[(off + i) % 36]) << (8 * i);
    return v;
  endfunction

  function automatic void close_element();
    push_result(KIND_END, 4'd0, p_id, 64'(p_pos));
    if (p_id == VENDOR_ID && p_pos >= 8'd21) begin
      p_vcommit = p_vshadow;
      p_vseen = 1'b1;
    end
    p_phase = PH_ID;
  endfunction

  function automatic void walk_element(logic [7:0] b);
    case (p_phase)
      PH_ID: begin
        p_id = b;
        p_phase = PH_LEN;
      end
      PH_LEN: begin
        p_left = b;
        p_pos = '0;
        if (b == 8'd0) close_element();
        else p_phase = PH_DATA;
      end
      default: begin
        if (p_pos < 8'd21) p_vshadow[p_pos] = b;
        push_result(KIND_DATA, 4'd0, p_id, 64'(b));
        p_pos = p_pos + 8'd1;
        p_left = p_left - 8'd1;
        if (p_left == 8'd0) close_element();
      end
    endcase
  endfunction

  function automatic void emit_summary();
    logic [63:0] w [9];
    logic [15:0] fc;
    logic [31:0] fcs;
    logic        mgmt, beacon, zero_hit;
    logic [63:0] magic;
    for (int i = 0; i < 9; i++) w[i] = '0;
    if (p_count < MIN_FRAME_BYTES) begin
      w[0] = 64'd1;
    end else begin
      fc = 16'(hdr_bytes(0, 2));
      fcs = {p_delay[3], p_delay[2], p_delay[1], p_delay[0]};
      mgmt = fc[3:2] == 2'd0;
      beacon = mgmt && fc[7:4] == 4'd8;
      magic = '0;
      zero_hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
        if (p_vcommit[4 + i] == 8'd0) zero_hit = 1'b1;
        if (!zero_hit) magic |= 64'(p_vcommit[4 + i]) << (8 * i);
      end
      w[0] = {32'd0, 16'(hdr_bytes(34, 2)), 9'd0, p_vseen && magic == p_magic, p_vseen,
              beacon && p_phase == PH_ID, beacon, mgmt, ~p_crc == fcs, 1'b0};
      w[1] = {16'(hdr_bytes(32, 2)), 16'(hdr_bytes(22, 2)), 16'(hdr_bytes(2, 2)), fc};
      w[2] = hdr_bytes(4, 6);
      w[3] = hdr_bytes(10, 6);
      w[4] = hdr_bytes(16, 6);
      w[5] = hdr_bytes(24, 8);
      w[6] = {8'd0, p_vcommit[13], p_vcommit[14], p_vcommit[12], p_vcommit[3],
              p_vcommit[2], p_vcommit[1], p_vcommit[0]};
      w[7] = {16'd0, p_vcommit[17], p_vcommit[18], p_vcommit[19], p_vcommit[20],
              p_vcommit[15], p_vcommit[16]};
      w[8] = magic;
    end
    for (int i = 0; i < 9; i++) push_result(KIND_SUM, 4'(i), 8'd0, w[i]);
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eof);
    int n_prior = expected_results.size();
    logic [7:0] body;
    if (p_count >= 4) begin
      body = p_delay[0];
      p_crc = crc_step(p_crc, body);
      if (p_count - 4 < 36) p_hdr[p_count - 4] = body;
      else walk_element(body);
    end
    p_delay[0] = p_delay[1];
    p_delay[1] = p_delay[2];
    p_delay[2] = p_delay[3];
    p_delay[3] = b;
    if (p_count < MAX_FRAME_BYTES) p_count++;
    if (eof) begin
      emit_summary();
      clear_frame();
    end
    if (expected_results.size() > n_prior)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  // frame builder
  function automatic void add_byte(logic [7:0] b, logic eof = 1'b0);
    beat_t t;
    t.b = b; t.eof = eof;
    pending_beats.insert(pending_beats.size(), t);
  endfunction

  function automatic logic [31:0] crc_of(logic [7:0] body [$]);
    logic [31:0] c = '1;
    foreach (body[i]) c = crc_step(c, body[i]);
    return ~c;
  endfunction

  // body: header + elements; fcs good or corrupted
  function automatic void build_frame(logic [63:0] magic, bit good_fcs, bit beacon_fc,
                                      int n_elems, bit vendor, bit truncate);
    logic [7:0] body [$];
    logic [31:0] fcs;
    int len, vpos;
    for (int i = 0; i < 36; i++) body.insert(body.size(), 8'($urandom));
    if (beacon_fc) body[0] = {4'd8, 2'd0, 2'($urandom)};
    vpos = vendor ? $urandom_range(0, n_elems) : -1;
    for (int e = 0; e <= n_elems; e++) begin
      if (e == vpos) begin
        len = $urandom_range(21, 30);
        body.insert(body.size(), VENDOR_ID);
        body.insert(body.size(), 8'(len));
        for (int i = 0; i < len; i++) begin
          if (i >= 4 && i < 12) body.insert(body.size(), magic[8 * (i - 4) +: 8]);
          else body.insert(body.size(), 8'($urandom));
        end
      end else if (e < n_elems) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        body.insert(body.size(), 8'($urandom));
        body.insert(body.size(), 8'(len));
        for (int i = 0; i < len; i++) body.insert(body.size(), 8'($urandom));
      end
    end
    if (truncate) begin
      body.insert(body.size(), 8'($urandom));
      body.insert(body.size(), 8'($urandom_range(5, 255)));
      body.insert(body.size(), 8'($urandom));
    end
    fcs = crc_of(body);
    if (!good_fcs) fcs ^= 32'(1) << $urandom_range(0, 31);
    foreach (body[i]) add_byte(body[i]);
    add_byte(fcs[7:0]);
    add_byte(fcs[15:8]);
    add_byte(fcs[23:16]);
    add_byte(fcs[31:24], 1'b1);
  endfunction

  function automatic logic [63:0] rand_magic();
    logic [63:0] m = {$urandom, $urandom};
    int keep = $urandom_range(0, 8);
    for (int i = 0; i < 8; i++) begin
      if (i >= keep) m[8 * i +: 8] = 8'd0;
      else if (m[8 * i +: 8] == 8'd0) m[8 * i +: 8] = 8'h41;
    end
    return m;
  endfunction

  task automatic write_magic(logic [63:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_MAGIC; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    p_magic = v;
  endtask

  task automatic wait_drain();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic eof);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ?
          (($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 2)) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_frame <= eof;
    do @(posedge clk); while (!in_ch.ready);
    predict_byte(b, eof);
  endtask

  task automatic send_pending(bit steady);
    beat_t t;
    while (pending_beats.size() != 0) begin
      t = pending_beats.pop_front();
      if (steady) begin
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= t.b;
        in_ch.end_of_frame <= t.eof;
        do @(posedge clk); while (!in_ch.ready);
        predict_byte(t.b, t.eof);
      end else begin
        send_byte(t.b, t.eof);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // sink side: random stalls, compare each beat
  bit stall_free = 0;
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.kind, out_ch.word_index, out_ch.element_id, out_ch.value,
               out_ch.last};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: kind %0d/%0d idx %0d/%0d id %h/%h value %h/%h last %b/%b",
                       want.kind, got.kind, want.word_index, got.word_index,
                       want.element_id, got.element_id, want.value, got.value,
                       want.last, got.last);
          end
        end
      end
      if (stall_free) begin
        out_ch.ready <= 1'b1;
      end else if (sink_hold != 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        sink_hold = $urandom_range(5, 20);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("[wifi_beacon_frame_parser] ERROR");
      $finish;
    end
  end

  task automatic directed_part();
    row_t r;
    int idx;
    // short frame: nine words, only the short flag set
    for (int i = 0; i < 4; i++) begin
      r = '{b: 8'(i), eof: 1'b0, chk: 1'b0, kind: KIND_SUM, widx: 4'd0, val: '0};
      directed_rows.insert(directed_rows.size(), r);
    end
    r = '{b: 8'hFF, eof: 1'b1, chk: 1'b1, kind: KIND_SUM, widx: 4'd0, val: 64'd1};
    directed_rows.insert(directed_rows.size(), r);
    r = '{b: 8'h00, eof: 1'b1, chk: 1'b1, kind: KIND_SUM, widx: 4'd0, val: 64'd1};
    directed_rows.insert(directed_rows.size(), r);
    r = '{b: 8'h80, eof: 1'b0, chk: 1'b0, kind: KIND_SUM, widx: 4'd0, val: '0};
    directed_rows.insert(directed_rows.size(), r);
    r = '{b: 8'h7F, eof: 1'b1, chk: 1'b1, kind: KIND_SUM, widx: 4'd0, val: 64'd1};
    directed_rows.insert(directed_rows.size(), r);
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_byte(r.b, r.eof);
      if (r.chk) begin
        idx = expected_results.size() - int'(NUM_WORDS);
        if (expected_results[idx].kind !== r.kind ||
            expected_results[idx].word_index !== r.widx ||
            expected_results[idx].value !== r.val) begin
          errors++;
          if (errors <= 10)
            $display("directed row %0d: predicted %h", i, expected_results[idx].value);
        end
      end
    end
    in_ch.valid <= 1'b0;
    wait_drain();
    // good beacon with vendor magic, truncated element with bad FCS, non-beacon without vendor, odd leftover
    build_frame(p_magic, 1, 1, 2, 1, 0);
    build_frame(p_magic, 0, 1, 1, 0, 1);
    build_frame(p_magic, 1, 0, 0, 0, 0);
    for (int i = 0; i < 40; i++) add_byte(8'($urandom));
    add_byte(8'hFF, 1'b1);
    send_pending(1);
    wait_drain();
  endtask

  initial begin
    int sent;
    int phase;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.end_of_frame = 1'b0;
    for (int i = 0; i < 36; i++) p_hdr[i] = '0;
    for (int i = 0; i < 21; i++) p_vshadow[i] = '0;
    p_magic = '0;
    clear_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_part();
    write_magic(64'h0000_0000_4F4C_4548);
    build_frame(64'h0000_0000_4F4C_4548, 1, 1, 1, 1, 0);
    send_pending(0);
    wait_drain();
    write_magic('1);
    build_frame('1, 1, 1, 1, 1, 0);
    send_pending(0);
    wait_drain();
    sent = 0;
    phase = 0;
    while (sent < 120) begin
      if (sent > phase * 40) begin
        wait_drain();
        write_magic($urandom_range(0, 3) == 0 ? {$urandom, $urandom} : rand_magic());
        phase++;
      end
      stall_free = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 45)) add_byte(8'($urandom), 1'b0);
          add_byte(8'($urandom), 1'b1);
        end
        1: build_frame(($urandom_range(0, 1) ? p_magic : rand_magic()), 1, 1,
                       $urandom_range(0, 4), 1, 1);
        2: build_frame(rand_magic(), $urandom_range(0, 1), $urandom_range(0, 1),
                       $urandom_range(0, 3), $urandom_range(0, 1), 0);
        default: build_frame(($urandom_range(0, 2) ? p_magic : rand_magic()),
                             ($urandom_range(0, 5) != 0), 1, $urandom_range(0, 4),
                             ($urandom_range(0, 3) != 0), 0);
      endcase
      sent += pending_beats.size();
      send_pending($urandom_range(0, 3) == 0);
    end
    stall_free = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("[wifi_beacon_frame_parser] OK");
    else
      $display("[wifi_beacon_frame_parser] ERROR");
    $finish;
  end
endmodule
